### rtl/pst_pkg.sv
// Shared types, token kind codes and helper functions for the tokenizer.
// No dependencies; used by the scanner, the token queue, the top level and the token checker.
`default_nettype none
package pst_pkg;

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_NEWLINE = 5'd1;
    localparam logic [4:0] K_INDENT  = 5'd2;
    localparam logic [4:0] K_NAME    = 5'd3;
    localparam logic [4:0] K_NUMBER  = 5'd4;
    localparam logic [4:0] K_HEX     = 5'd5;
    localparam logic [4:0] K_STRING  = 5'd6;
    localparam logic [4:0] K_DOC     = 5'd7;
    localparam logic [4:0] K_PUNCT   = 5'd8;
    localparam logic [4:0] K_LE      = 5'd9;
    localparam logic [4:0] K_GE      = 5'd10;
    localparam logic [4:0] K_ADDEQ   = 5'd11;
    localparam logic [4:0] K_INC     = 5'd12;
    localparam logic [4:0] K_SUBEQ   = 5'd13;
    localparam logic [4:0] K_DEC     = 5'd14;
    localparam logic [4:0] K_MULEQ   = 5'd15;
    localparam logic [4:0] K_POW     = 5'd16;
    localparam logic [4:0] K_DIVEQ   = 5'd17;
    localparam logic [4:0] K_FDIV    = 5'd18;
    localparam logic [4:0] K_BAD     = 5'd19;
    localparam logic [4:0] K_TOOLONG = 5'd20;

    localparam int MAX_PER_CHAR = 3;
    localparam int OUT_LINE_W   = 24;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] first;
        logic [7:0] len;
    } t_res;

    typedef struct packed {
        t_res                  res;
        logic [OUT_LINE_W-1:0] line;
        logic                  last;
    } t_tok;

    typedef struct packed {
        logic [1:0] count;
        t_res [MAX_PER_CHAR-1:0] res;
    } t_push;

    function automatic t_res mk_res(logic [4:0] kind, logic [7:0] first, logic [15:0] len);
        t_res r;
        r.kind  = kind;
        r.first = first;
        r.len   = (len > 16'd255) ? 8'd255 : len[7:0];
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic [4:0] pair_kind(logic [7:0] s, logic [7:0] c);
        logic [4:0] k;
        k = K_EOF;
        if (c == "=") begin
            unique case (s)
                "<":     k = K_LE;
                ">":     k = K_GE;
                "+":     k = K_ADDEQ;
                "-":     k = K_SUBEQ;
                "*":     k = K_MULEQ;
                "/":     k = K_DIVEQ;
                default: k = K_EOF;
            endcase
        end else if (c == s) begin
            unique case (s)
                "+":     k = K_INC;
                "-":     k = K_DEC;
                "*":     k = K_POW;
                "/":     k = K_FDIV;
                default: k = K_EOF;
            endcase
        end
        return k;
    endfunction

    // Walks the number grammar from sub-state s0; returns {accepted, next sub-state}.
    function automatic logic [3:0] num_take(logic [2:0] s0, logic [7:0] c);
        logic [3:0] s;
        logic       found;
        logic       lp;
        logic       okb;
        logic [3:0] r;
        s     = {1'b0, s0};
        found = 1'b0;
        r     = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (!found && (s <= 4'd7)) begin
                lp = (s == 4'd0) || (s == 4'd2) || (s == 4'd5) || (s == 4'd7);
                if (lp) okb = is_digit(c);
                else if ((s == 4'd1) || (s == 4'd6)) okb = (c == ".");
                else if (s == 4'd3) okb = (c == "e");
                else okb = (c == "-");
                if (okb) begin
                    found = 1'b1;
                    r = {1'b1, (lp ? s[2:0] : s[2:0] + 3'd1)};
                end else begin
                    s = (s == 4'd3) ? 4'd5 : s + 4'd1;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/pst_chr_if.sv
// Handshake interfaces for the character input channel and the token output channel.
// No dependencies; the token fields are plain logic vectors.
`default_nettype none
interface pst_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_input;
    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

interface pst_tok_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic [7:0] first_char;
    logic [7:0] lexeme_length;
    logic [23:0] line_number;
    logic       last_of_run;
    modport source (output valid, output token_kind, output first_char, output lexeme_length,
                    output line_number, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input first_char, input lexeme_length,
                  input line_number, input last_of_run, output ready);
endinterface
`default_nettype wire

### rtl/pst_scan.sv
// Scanner state and the step logic that turns a character into up to two tokens.
// Depends on pst_pkg.
`default_nettype none
module pst_scan #(
    parameter int MAX_LEXEME = 128,
    parameter int LINE_WIDTH = 24
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_step,
    input  wire  [7:0]              i_char,
    input  wire                     i_eoi,
    output pst_pkg::t_push          o_push,
    output logic [LINE_WIDTH-1:0]   o_line
);
    localparam int LW = $clog2(MAX_LEXEME);
    localparam logic [LW-1:0] LEN_CAP = LW'(MAX_LEXEME - 2);

    localparam logic [4:0] M_IDLE       = 5'd0;
    localparam logic [4:0] M_NL_PLAIN   = 5'd1;
    localparam logic [4:0] M_NL_COMMENT = 5'd2;
    localparam logic [4:0] M_INDENT     = 5'd3;
    localparam logic [4:0] M_COMMENT    = 5'd4;
    localparam logic [4:0] M_DOT        = 5'd5;
    localparam logic [4:0] M_OP         = 5'd6;
    localparam logic [4:0] M_NAME       = 5'd7;
    localparam logic [4:0] M_ZERO       = 5'd8;
    localparam logic [4:0] M_HEX        = 5'd9;
    localparam logic [4:0] M_DQ_OPEN    = 5'd10;
    localparam logic [4:0] M_DQ_TWO     = 5'd11;
    localparam logic [4:0] M_DQ_BODY    = 5'd12;
    localparam logic [4:0] M_DOC        = 5'd13;
    localparam logic [4:0] M_SQ_BODY    = 5'd14;
    localparam logic [4:0] M_NUM0       = 5'd15;
    localparam logic [4:0] M_NUM7       = 5'd22;

    logic [4:0]            r_mode, n_mode;
    logic [LW-1:0]         r_len, n_len;
    logic [LINE_WIDTH-1:0] r_line, n_line;
    logic [7:0]            r_sc, n_sc;
    logic [1:0]            r_qr, n_qr;
    logic                  r_ovf, n_ovf;

    pst_pkg::t_res [2:0] res;
    logic [1:0] cnt;
    logic       do_start;
    logic       inc;
    logic [3:0] nt;
    logic [4:0] pk;
    logic [7:0] c;

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_sc   = r_sc;
        n_qr   = r_qr;
        n_ovf  = r_ovf;
        res    = '0;
        cnt    = 2'd0;
        do_start = 1'b0;
        inc    = 1'b0;
        c      = i_char;
        nt     = 4'd0;
        pk     = pst_pkg::K_EOF;
        if (i_eoi) begin
            if ((r_mode >= M_NUM0) && (r_mode <= M_NUM7)) begin
                res[cnt] = pst_pkg::mk_res(r_ovf ? pst_pkg::K_TOOLONG : pst_pkg::K_NUMBER,
                                           r_sc, 16'(r_len));
                cnt = cnt + 2'd1;
            end else begin
                unique case (r_mode)
                    M_NL_COMMENT: begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_NEWLINE, 8'h0a, 16'd1);
                        cnt = cnt + 2'd1;
                    end
                    M_DOT: begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_PUNCT, ".", 16'd1);
                        cnt = cnt + 2'd1;
                    end
                    M_OP: begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_PUNCT, r_sc, 16'd1);
                        cnt = cnt + 2'd1;
                    end
                    M_INDENT, M_NAME, M_ZERO, M_HEX, M_DQ_TWO: begin
                        if (r_mode == M_INDENT) pk = pst_pkg::K_INDENT;
                        else if (r_mode == M_NAME) pk = pst_pkg::K_NAME;
                        else if (r_mode == M_ZERO) pk = pst_pkg::K_NUMBER;
                        else if (r_mode == M_HEX) pk = pst_pkg::K_HEX;
                        else pk = pst_pkg::K_STRING;
                        res[cnt] = pst_pkg::mk_res(r_ovf ? pst_pkg::K_TOOLONG : pk,
                                                   r_sc, 16'(r_len));
                        cnt = cnt + 2'd1;
                    end
                    M_DQ_OPEN, M_DQ_BODY, M_SQ_BODY, M_DOC: begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_BAD, r_sc, 16'(r_len));
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
            end
            res[cnt] = pst_pkg::mk_res(pst_pkg::K_EOF, 8'd0, 16'd0);
            cnt = cnt + 2'd1;
            n_mode = M_IDLE;
            n_qr   = 2'd0;
        end else if ((r_mode >= M_NUM0) && (r_mode <= M_NUM7)) begin
            nt = pst_pkg::num_take(3'(r_mode - M_NUM0), c);
            if (nt[3]) begin
                if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                if (n_len == LEN_CAP) n_ovf = 1'b1;
                n_mode = M_NUM0 + {2'b00, nt[2:0]};
            end else begin
                res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG : pst_pkg::K_NUMBER,
                                           n_sc, 16'(n_len));
                cnt = cnt + 2'd1;
                do_start = 1'b1;
            end
        end else begin
            unique case (r_mode)
                M_NL_PLAIN, M_NL_COMMENT: begin
                    res[cnt] = pst_pkg::mk_res(pst_pkg::K_NEWLINE, 8'h0a, 16'd1);
                    cnt = cnt + 2'd1;
                    n_mode = M_IDLE;
                    if (c == " ") begin
                        n_sc = c; n_len = LW'(1); n_ovf = 1'b0; n_qr = 2'd0;
                        n_mode = M_INDENT;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                M_INDENT: begin
                    if (c == " ") begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                    end else begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_INDENT, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == 8'h0a) begin
                        inc = 1'b1;
                        n_mode = M_NL_COMMENT;
                    end
                end
                M_DOT: begin
                    if (pst_pkg::is_digit(c)) begin
                        nt = pst_pkg::num_take(3'd0, c);
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                        n_mode = M_NUM0 + {2'b00, nt[2:0]};
                    end else begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_PUNCT, ".", 16'd1);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_OP: begin
                    pk = pst_pkg::pair_kind(r_sc, c);
                    if (pk != pst_pkg::K_EOF) begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG : pk,
                                                   n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else begin
                        res[cnt] = pst_pkg::mk_res(pst_pkg::K_PUNCT, r_sc, 16'd1);
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_NAME: begin
                    if (pst_pkg::is_alpha(c) || pst_pkg::is_digit(c) || (c == "_")) begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                    end else begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_NAME, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_ZERO: begin
                    nt = pst_pkg::num_take(3'd0, c);
                    if (c == "x") begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                        n_mode = M_HEX;
                    end else if (nt[3]) begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                        n_mode = M_NUM0 + {2'b00, nt[2:0]};
                    end else begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_NUMBER, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_HEX: begin
                    if (pst_pkg::is_hex(c)) begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                    end else begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_HEX, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_DQ_OPEN: begin
                    if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                    if (n_len == LEN_CAP) n_ovf = 1'b1;
                    n_mode = (c == "\"") ? M_DQ_TWO : M_DQ_BODY;
                end
                M_DQ_TWO: begin
                    if (c == "\"") begin
                        if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                        if (n_len == LEN_CAP) n_ovf = 1'b1;
                        n_qr = 2'd0;
                        n_mode = M_DOC;
                    end else begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_STRING, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_DQ_BODY, M_SQ_BODY: begin
                    if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                    if (n_len == LEN_CAP) n_ovf = 1'b1;
                    if (((r_mode == M_DQ_BODY) && (c == "\"")) ||
                        ((r_mode == M_SQ_BODY) && (c == "'"))) begin
                        res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                         : pst_pkg::K_STRING, n_sc, 16'(n_len));
                        cnt = cnt + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_DOC: begin
                    if (c == 8'h0a) inc = 1'b1;
                    if (n_len < LEN_CAP) n_len = n_len + LW'(1);
                    if (n_len == LEN_CAP) n_ovf = 1'b1;
                    if (c == "\"") begin
                        n_qr = r_qr + 2'd1;
                        if (n_qr == 2'd3) begin
                            res[cnt] = pst_pkg::mk_res(n_ovf ? pst_pkg::K_TOOLONG
                                                             : pst_pkg::K_DOC, n_sc, 16'(n_len));
                            cnt = cnt + 2'd1;
                            n_mode = M_IDLE;
                        end
                    end else begin
                        n_qr = 2'd0;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        if (do_start) begin
            n_mode = M_IDLE;
            if (c == 8'h0a) begin
                inc = 1'b1;
                n_mode = M_NL_PLAIN;
            end else if (c == " ") begin
                n_mode = M_IDLE;
            end else if ((c == ":") || (c == ",") || (c == "{") || (c == "}") || (c == "(") ||
                         (c == ")") || (c == "[") || (c == "]") || (c == "=")) begin
                res[cnt] = pst_pkg::mk_res(pst_pkg::K_PUNCT, c, 16'd1);
                cnt = cnt + 2'd1;
            end else if (c == "#") begin
                n_mode = M_COMMENT;
            end else if ((c == ".") || (c == "<") || (c == ">") || (c == "+") || (c == "-") ||
                         (c == "*") || (c == "/") || (c == "\"") || (c == "'") ||
                         pst_pkg::is_alpha(c) || (c == "_") || pst_pkg::is_digit(c)) begin
                n_sc = c; n_len = LW'(1); n_ovf = 1'b0; n_qr = 2'd0;
                if (c == ".") n_mode = M_DOT;
                else if (c == "\"") n_mode = M_DQ_OPEN;
                else if (c == "'") n_mode = M_SQ_BODY;
                else if (c == "0") n_mode = M_ZERO;
                else if (pst_pkg::is_digit(c)) n_mode = M_NUM0;
                else if (pst_pkg::is_alpha(c) || (c == "_")) n_mode = M_NAME;
                else n_mode = M_OP;
            end else begin
                res[cnt] = pst_pkg::mk_res(pst_pkg::K_BAD, c, 16'd1);
                cnt = cnt + 2'd1;
            end
        end

        n_line = r_line;
        if (inc && (r_line != {LINE_WIDTH{1'b1}})) n_line = r_line + LINE_WIDTH'(1);
    end

    always_comb begin
        o_push.count = cnt;
        o_push.res   = res;
        o_line       = r_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len  <= '0;
            r_line <= LINE_WIDTH'(1);
            r_sc   <= 8'd0;
            r_qr   <= 2'd0;
            r_ovf  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_line <= n_line;
            r_sc   <= n_sc;
            r_qr   <= n_qr;
            r_ovf  <= n_ovf;
        end
    end
endmodule
`default_nettype wire

### rtl/pst_tokq.sv
// Token queue: takes up to three tokens per cycle and hands them out one beat at a time.
// Depends on pst_pkg.
`default_nettype none
module pst_tokq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_en,
    input  pst_pkg::t_push      i_push,
    input  wire  [23:0]         i_line,
    output logic                o_room,
    output logic                o_valid,
    output pst_pkg::t_tok       o_tok,
    input  wire                 i_pop
);
    localparam int DEPTH = 8;
    localparam int PW    = $clog2(DEPTH);

    pst_pkg::t_tok      r_mem [DEPTH];
    logic [PW-1:0]      r_wp, r_rp;
    logic [PW:0]        r_cnt, n_cnt;
    logic [PW:0]        push_n;
    logic               pop;

    assign pop     = i_pop && (r_cnt != '0);
    assign push_n  = i_push_en ? (PW+1)'(i_push.count) : '0;
    assign n_cnt   = r_cnt + push_n - (PW+1)'(pop);
    assign o_room  = (r_cnt <= (PW+1)'(DEPTH - pst_pkg::MAX_PER_CHAR));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_en) begin
            for (int k = 0; k < pst_pkg::MAX_PER_CHAR; k++) begin
                if (2'(k) < i_push.count) begin
                    r_mem[r_wp + PW'(k)].res  <= i_push.res[k];
                    r_mem[r_wp + PW'(k)].line <= i_line;
                    r_mem[r_wp + PW'(k)].last <= (2'(k) == (i_push.count - 2'd1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + push_n[PW-1:0];
            if (pop) r_rp <= r_rp + PW'(1);
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

### rtl/python_subset_tokenizer.sv
// Top level of the tokenizer: input register, scanner and token queue.
// Depends on pst_pkg, pst_chr_if, pst_tok_if, pst_scan and pst_tokq.
//
//   Port     Dir  Beat carries
//   i_chr    in   char_code, end_of_input
//   o_tok    out  token_kind, first_char, lexeme_length, line_number, last_of_run
//
// One character is taken each cycle while the queue has room; a character is held
// in the input register and its tokens are then written into the queue, whose head
// drives the output. Tokens leave one beat per cycle while the sink is ready, so the
// sustained rate is one character per cycle while the characters yield one token or
// fewer on average. The input stalls while the eight-entry queue has fewer than three
// free slots. Reset is synchronous and leaves the line counter at one.
`default_nettype none
module python_subset_tokenizer #(
    parameter int MAX_LEXEME = 128,
    parameter int LINE_WIDTH = 24
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pst_chr_if.sink    i_chr,
    pst_tok_if.source  o_tok
);
    logic                  r_in_valid;
    logic [7:0]            r_char;
    logic                  r_eoi;
    logic                  room;
    logic                  step;
    pst_pkg::t_push        push;
    logic [LINE_WIDTH-1:0] line;
    logic [23:0]           line_out;
    pst_pkg::t_tok         head;
    logic                  head_valid;

    assign step        = r_in_valid && room;
    assign i_chr.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_chr.ready) begin
            r_in_valid <= i_chr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chr.ready && i_chr.valid) begin
            r_char <= i_chr.char_code;
            r_eoi  <= i_chr.end_of_input;
        end
    end

    pst_scan #(.MAX_LEXEME(MAX_LEXEME), .LINE_WIDTH(LINE_WIDTH)) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_char  (r_char),
        .i_eoi   (r_eoi),
        .o_push  (push),
        .o_line  (line)
    );

    if (LINE_WIDTH >= 24) begin : g_line_cut
        assign line_out = line[23:0];
    end else begin : g_line_ext
        assign line_out = {{(24 - LINE_WIDTH){1'b0}}, line};
    end

    pst_tokq u_tokq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (step),
        .i_push    (push),
        .i_line    (line_out),
        .o_room    (room),
        .o_valid   (head_valid),
        .o_tok     (head),
        .i_pop     (o_tok.ready)
    );

    assign o_tok.valid         = head_valid;
    assign o_tok.token_kind    = head.res.kind;
    assign o_tok.first_char    = head.res.first;
    assign o_tok.lexeme_length = head.res.len;
    assign o_tok.line_number   = head.line;
    assign o_tok.last_of_run   = head.last;
endmodule
`default_nettype wire

### tb/sv/python_subset_tokenizer_chk.sv
// Token checker for the tokenizer: predicts the tokens of each accepted character beat
// and compares them with the output beats. Depends on pst_pkg, pst_chr_if and pst_tok_if.
`default_nettype none
module python_subset_tokenizer_chk (
    input  wire     i_clk,
    input  wire     i_rst_n,
    pst_chr_if      i_chr,
    pst_tok_if      i_tok,
    output int      o_errors,
    output int      o_pending,
    output int      o_tokens
);
    localparam int MAX_LEX = 128;

    typedef enum logic [4:0] {
        S_IDLE, S_NL_PLAIN, S_NL_COMMENT, S_INDENT, S_COMMENT, S_DOT, S_OP, S_NAME,
        S_ZERO, S_HEX, S_DQ_OPEN, S_DQ_TWO, S_DQ_BODY, S_DOC, S_SQ_BODY, S_NUM
    } t_scan;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  first;
        logic [7:0]  len;
        logic [23:0] line;
        logic        last;
    } t_expect;

    t_expect     tok_queue[$];
    t_expect     step_toks[$];
    t_scan       mode;
    logic [2:0]  num_sub;
    int unsigned tok_len;
    logic [23:0] line_cnt;
    logic [7:0]  first_ch;
    int unsigned quotes;
    logic        too_long;

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic bit alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic bit hexd(logic [7:0] c);
        return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    task automatic push_tok(logic [4:0] kind, logic [7:0] first, int unsigned len);
        t_expect e;
        if (step_toks.size() < 3) begin
            e.kind  = kind;
            e.first = first;
            e.len   = len > 255 ? 8'd255 : len[7:0];
            e.line  = line_cnt;
            e.last  = 1'b0;
            step_toks.push_back(e);
        end
    endtask

    task automatic bump_line();
        if (line_cnt != 24'hFFFFFF) line_cnt++;
    endtask

    task automatic open_tok(logic [7:0] c);
        first_ch = c;
        tok_len  = 1;
        too_long = 1'b0;
        quotes   = 0;
    endtask

    task automatic extend();
        if (tok_len < MAX_LEX - 2) tok_len++;
        if (tok_len == MAX_LEX - 2) too_long = 1'b1;
    endtask

    task automatic close_tok(logic [4:0] kind);
        push_tok(too_long ? pst_pkg::K_TOOLONG : kind, first_ch, tok_len);
        mode = S_IDLE;
    endtask

    function automatic logic [4:0] op_pair(logic [7:0] s, logic [7:0] c);
        if (c == "=") begin
            case (s)
                "<": return pst_pkg::K_LE;
                ">": return pst_pkg::K_GE;
                "+": return pst_pkg::K_ADDEQ;
                "-": return pst_pkg::K_SUBEQ;
                "*": return pst_pkg::K_MULEQ;
                "/": return pst_pkg::K_DIVEQ;
                default: return pst_pkg::K_EOF;
            endcase
        end
        if (c != s) return pst_pkg::K_EOF;
        case (s)
            "+": return pst_pkg::K_INC;
            "-": return pst_pkg::K_DEC;
            "*": return pst_pkg::K_POW;
            "/": return pst_pkg::K_FDIV;
            default: return pst_pkg::K_EOF;
        endcase
    endfunction

    task automatic number_step(logic [7:0] c, output bit took);
        int  s;
        bit  lp;
        bit  ok;
        s    = num_sub;
        took = 0;
        while (s <= 7) begin
            lp = (s == 0 || s == 2 || s == 5 || s == 7);
            if (lp) ok = dig(c);
            else if (s == 1 || s == 6) ok = (c == ".");
            else if (s == 3) ok = (c == "e");
            else ok = (c == "-");
            if (ok) begin
                extend();
                mode    = S_NUM;
                num_sub = 3'(lp ? s : s + 1);
                took    = 1;
                return;
            end
            s = (s == 3) ? 5 : s + 1;
        end
    endtask

    task automatic scan_start(logic [7:0] c);
        mode = S_IDLE;
        case (c)
            8'h0A: begin
                bump_line();
                mode = S_NL_PLAIN;
            end
            " ": ;
            ".": begin
                open_tok(c);
                mode = S_DOT;
            end
            ":", ",", "{", "}", "(", ")", "[", "]", "=": push_tok(pst_pkg::K_PUNCT, c, 1);
            "<", ">", "+", "-", "*", "/": begin
                open_tok(c);
                mode = S_OP;
            end
            "#": mode = S_COMMENT;
            "\"": begin
                open_tok(c);
                mode = S_DQ_OPEN;
            end
            "'": begin
                open_tok(c);
                mode = S_SQ_BODY;
            end
            "0": begin
                open_tok(c);
                mode = S_ZERO;
            end
            default: begin
                if (alpha(c) || c == "_") begin
                    open_tok(c);
                    mode = S_NAME;
                end else if (dig(c)) begin
                    open_tok(c);
                    mode    = S_NUM;
                    num_sub = 3'd0;
                end else begin
                    push_tok(pst_pkg::K_BAD, c, 1);
                end
            end
        endcase
    endtask

    task automatic scan_char(logic [7:0] c);
        bit         took;
        logic [4:0] k;
        case (mode)
            S_NUM: begin
                number_step(c, took);
                if (took) return;
                close_tok(pst_pkg::K_NUMBER);
            end
            S_NL_PLAIN, S_NL_COMMENT: begin
                push_tok(pst_pkg::K_NEWLINE, 8'h0A, 1);
                mode = S_IDLE;
                if (c == " ") begin
                    open_tok(c);
                    mode = S_INDENT;
                    return;
                end
            end
            S_INDENT: begin
                if (c == " ") begin
                    extend();
                    return;
                end
                close_tok(pst_pkg::K_INDENT);
            end
            S_COMMENT: begin
                if (c == 8'h0A) begin
                    bump_line();
                    mode = S_NL_COMMENT;
                end
                return;
            end
            S_DOT: begin
                if (dig(c)) begin
                    num_sub = 3'd0;
                    number_step(c, took);
                    return;
                end
                push_tok(pst_pkg::K_PUNCT, ".", 1);
            end
            S_OP: begin
                k = op_pair(first_ch, c);
                if (k != pst_pkg::K_EOF) begin
                    extend();
                    close_tok(k);
                    return;
                end
                push_tok(pst_pkg::K_PUNCT, first_ch, 1);
            end
            S_NAME: begin
                if (alpha(c) || dig(c) || c == "_") begin
                    extend();
                    return;
                end
                close_tok(pst_pkg::K_NAME);
            end
            S_ZERO: begin
                if (c == "x") begin
                    extend();
                    mode = S_HEX;
                    return;
                end
                num_sub = 3'd0;
                number_step(c, took);
                if (took) return;
                close_tok(pst_pkg::K_NUMBER);
            end
            S_HEX: begin
                if (hexd(c)) begin
                    extend();
                    return;
                end
                close_tok(pst_pkg::K_HEX);
            end
            S_DQ_OPEN: begin
                extend();
                mode = (c == "\"") ? S_DQ_TWO : S_DQ_BODY;
                return;
            end
            S_DQ_TWO: begin
                if (c == "\"") begin
                    extend();
                    quotes = 0;
                    mode   = S_DOC;
                    return;
                end
                close_tok(pst_pkg::K_STRING);
            end
            S_DQ_BODY: begin
                extend();
                if (c == "\"") close_tok(pst_pkg::K_STRING);
                return;
            end
            S_SQ_BODY: begin
                extend();
                if (c == "'") close_tok(pst_pkg::K_STRING);
                return;
            end
            S_DOC: begin
                if (c == 8'h0A) bump_line();
                extend();
                if (c == "\"") begin
                    quotes++;
                    if (quotes >= 3) close_tok(pst_pkg::K_DOC);
                end else begin
                    quotes = 0;
                end
                return;
            end
            default: ;
        endcase
        scan_start(c);
    endtask

    task automatic scan_end();
        case (mode)
            S_NUM, S_ZERO: close_tok(pst_pkg::K_NUMBER);
            S_NL_COMMENT:  push_tok(pst_pkg::K_NEWLINE, 8'h0A, 1);
            S_INDENT:      close_tok(pst_pkg::K_INDENT);
            S_DOT:         push_tok(pst_pkg::K_PUNCT, ".", 1);
            S_OP:          push_tok(pst_pkg::K_PUNCT, first_ch, 1);
            S_NAME:        close_tok(pst_pkg::K_NAME);
            S_HEX:         close_tok(pst_pkg::K_HEX);
            S_DQ_TWO:      close_tok(pst_pkg::K_STRING);
            S_DQ_OPEN, S_DQ_BODY, S_SQ_BODY, S_DOC: push_tok(pst_pkg::K_BAD, first_ch, tok_len);
            default: ;
        endcase
        push_tok(pst_pkg::K_EOF, 8'h00, 0);
        mode   = S_IDLE;
        quotes = 0;
    endtask

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("token field %s: expected %0h, got %0h", name, want, got);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (!i_rst_n) begin
            mode     = S_IDLE;
            num_sub  = 3'd0;
            tok_len  = 0;
            line_cnt = 24'd1;
            first_ch = 8'h00;
            quotes   = 0;
            too_long = 1'b0;
            o_errors = 0;
            o_tokens = 0;
            tok_queue.delete();
        end else begin
            if (i_tok.valid && i_tok.ready) begin
                o_tokens++;
                if (tok_queue.size() == 0) begin
                    $error("token beat with no token expected: kind %0d", i_tok.token_kind);
                    o_errors++;
                end else begin
                    e = tok_queue.pop_front();
                    check_field("token_kind", e.kind, i_tok.token_kind);
                    check_field("first_char", e.first, i_tok.first_char);
                    check_field("lexeme_length", e.len, i_tok.lexeme_length);
                    check_field("line_number", e.line, i_tok.line_number);
                    check_field("last_of_run", e.last, i_tok.last_of_run);
                end
            end
            if (i_chr.valid && i_chr.ready) begin
                step_toks.delete();
                if (i_chr.end_of_input) scan_end();
                else scan_char(i_chr.char_code);
                if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
                foreach (step_toks[j]) tok_queue.push_back(step_toks[j]);
            end
        end
        o_pending = tok_queue.size();
    end
endmodule
`default_nettype wire

### tb/sv/python_subset_tokenizer_tb.sv
// Testbench top for the tokenizer: clock, reset, source text stimulus, output stalls
// and the verdict. Depends on the interfaces, python_subset_tokenizer and python_subset_tokenizer_chk.
`default_nettype none
module python_subset_tokenizer_tb;
    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   tokens;
    int   src_idle;
    int   snk_stall;
    bit   hold_off;
    int   beats_sent;

    pst_chr_if chr ();
    pst_tok_if tok ();

    python_subset_tokenizer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr),
        .o_tok   (tok)
    );

    python_subset_tokenizer_chk i_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_chr     (chr),
        .i_tok     (tok),
        .o_errors  (errors),
        .o_pending (pending),
        .o_tokens  (tokens)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        tok.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) tok.ready <= 1'b0;
            else tok.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic send_beat(logic [7:0] c, logic eoi);
        while ($urandom_range(99) < src_idle) begin
            chr.valid <= 1'b0;
            @(posedge i_clk);
        end
        chr.valid        <= 1'b1;
        chr.char_code    <= c;
        chr.end_of_input <= eoi;
        @(posedge i_clk);
        while (!chr.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic src_quiet();
        chr.valid <= 1'b0;
    endtask

    task automatic send_text(string s);
        foreach (s[j]) send_beat(s[j], 1'b0);
    endtask

    function automatic logic [7:0] pick_char();
        string alphabet;
        alphabet = "abzAZ_09x5e.-+*/<>=()[]{}:,#'\" \n\n\"\"";
        case ($urandom_range(9))
            0:       return 8'($urandom_range(255));
            default: return alphabet[$urandom_range(alphabet.len() - 1)];
        endcase
    endfunction

    task automatic send_fragment();
        string frags[16];
        int    j;
        frags = '{"x = 12\n", "    y += 0x1fA\n", "f(a, b) ** 2\n", "# note\n",
                  "s = 'abc'\n", "t = \"q\"\n", "\"\"\"doc\nx\"\"\"\n", "1.5e-3.2 ",
                  ".7 // 3\n", "a <= b >= c\n", "i++ j-- k -= 1\n", "m *= 2 /= 4\n",
                  "[1, 2]{3: 4}\n", "\"\" 0 07 \n", "name_9 x.y\n", "  \n  z\n"};
        j = $urandom_range(15);
        send_text(frags[j]);
    endtask

    initial begin
        string longname;
        chr.valid        = 1'b0;
        chr.char_code    = 8'h00;
        chr.end_of_input = 1'b0;
        i_rst_n          = 1'b0;
        hold_off         = 1'b0;
        src_idle         = 0;
        snk_stall        = 0;
        beats_sent       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("a 0x9F 1.5e-2 \"\"\"d\"\"\" <= ** @");
        send_beat(8'hFF, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h00, 1'b1);
        send_text("'abc");
        send_beat(8'h00, 1'b1);
        send_text("# c\n");
        send_beat(8'h00, 1'b1);

        longname = "";
        repeat (130) longname = {longname, "q"};
        send_text({longname, " "});
        src_quiet();
        while (pending != 0) @(posedge i_clk);

        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                repeat (20) send_text("(,)");
                src_quiet();
            end
        join
        while (pending != 0) @(posedge i_clk);

        for (int ph = 0; ph < 4; ph++) begin
            src_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 62) : 0;
            snk_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 62) : 0;
            for (int n = 0; n < 7; n++) begin
                if ($urandom_range(2) == 0) begin
                    repeat ($urandom_range(6, 1)) send_beat(pick_char(), 1'b0);
                end else begin
                    send_fragment();
                end
                if ($urandom_range(5) == 0) send_beat(8'($urandom_range(255)), 1'b1);
            end
        end
        send_beat(8'h00, 1'b1);
        src_quiet();

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d character beats covering all token kinds, end-of-input cases,",
                 beats_sent);
        $display("an over-long name and output back-pressure; %0d tokens checked.", tokens);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
